### sv/assert_macros.svh
// Assertion helpers used by the esd_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication shorthand: antecedent must be followed next cycle by consequent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/esd_pkg.sv
// ---------------------------------------------------------------------------
// esd_pkg
// Shared types and codes of the serial escape sequence detector.
// ---------------------------------------------------------------------------
package esd_pkg;

    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_LEAVE = 2'd2;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CMD   = 2'd1;
    localparam logic [1:0] KIND_ENTER = 2'd2;
    localparam logic [1:0] KIND_LEAVE = 2'd3;

    localparam logic [2:0] REG_MARKER_CHAR  = 3'd0;
    localparam logic [2:0] REG_MARKER_COUNT = 3'd1;
    localparam logic [2:0] REG_GUARD        = 3'd2;
    localparam logic [2:0] REG_INTER_MARKER = 3'd3;
    localparam logic [2:0] REG_CMD_IDLE     = 3'd4;

    // One queued job: a run of repeated marker bytes, then an optional tail result.
    typedef struct packed {
        logic [3:0] rep;
        logic [7:0] mbyte;
        logic       tail_v;
        logic [1:0] tail_kind;
        logic [7:0] tail_byte;
    } job_t;

endpackage

### sv/esd_front.sv
// ---------------------------------------------------------------------------
// esd_front
// Configuration registers, escape state machine and job classification.
// ---------------------------------------------------------------------------
module esd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    input  logic [7:0]        rx_byte,
    input  logic              cfg_valid,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output esd_pkg::job_t     q_job
);
    import esd_pkg::*;

    typedef enum logic [4:0] {
        M_WAIT    = 5'b00001,
        M_ARMED   = 5'b00010,
        M_MARKERS = 5'b00100,
        M_CLOSING = 5'b01000,
        M_COMMAND = 5'b10000
    } mode_t;

    logic [7:0]  marker_char_reg;
    logic [3:0]  marker_count_reg;
    logic [15:0] guard_reg;
    logic [15:0] inter_reg;
    logic [15:0] cmd_idle_reg;

    mode_t       mode_reg, mode_next;
    logic [15:0] idle_reg, idle_next;
    logic [3:0]  ms_reg, ms_next;

    logic [15:0] idle_inc;
    logic [3:0]  ms_inc;
    logic        is_marker;
    logic        accept;
    job_t        job;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign idle_inc  = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign ms_inc    = ms_reg + 4'd1;
    assign is_marker = (rx_byte == marker_char_reg);

    always_comb
    begin
        mode_next     = mode_reg;
        idle_next     = idle_reg;
        ms_next       = ms_reg;
        job.rep       = 4'd0;
        job.mbyte     = marker_char_reg;
        job.tail_v    = 1'b0;
        job.tail_kind = KIND_DATA;
        job.tail_byte = 8'd0;
        case (op)
            OP_BYTE:
            begin
                idle_next     = 16'd0;
                job.tail_byte = rx_byte;
                case (mode_reg)
                    M_WAIT:
                    begin
                        job.tail_v = 1'b1;
                    end
                    M_ARMED:
                    begin
                        if (is_marker)
                        begin
                            ms_next   = 4'd1;
                            mode_next = (marker_count_reg <= 4'd1) ? M_CLOSING : M_MARKERS;
                        end
                        else
                        begin
                            job.tail_v = 1'b1;
                            mode_next  = M_WAIT;
                            ms_next    = 4'd0;
                        end
                    end
                    M_MARKERS:
                    begin
                        if (is_marker)
                        begin
                            ms_next = ms_inc;
                            if (ms_inc >= marker_count_reg)
                            begin
                                mode_next = M_CLOSING;
                            end
                        end
                        else
                        begin
                            job.rep    = ms_reg;
                            job.tail_v = 1'b1;
                            mode_next  = M_WAIT;
                            ms_next    = 4'd0;
                        end
                    end
                    M_CLOSING:
                    begin
                        job.rep    = ms_reg;
                        job.tail_v = 1'b1;
                        mode_next  = M_WAIT;
                        ms_next    = 4'd0;
                    end
                    default:
                    begin
                        job.tail_v    = 1'b1;
                        job.tail_kind = KIND_CMD;
                    end
                endcase
            end
            OP_TICK:
            begin
                idle_next = idle_inc;
                case (mode_reg)
                    M_WAIT:
                    begin
                        if (idle_inc >= guard_reg)
                        begin
                            idle_next = 16'd0;
                            mode_next = M_ARMED;
                        end
                    end
                    M_ARMED:
                    begin
                    end
                    M_MARKERS:
                    begin
                        if (idle_inc >= inter_reg)
                        begin
                            job.rep   = ms_reg;
                            mode_next = M_WAIT;
                            ms_next   = 4'd0;
                        end
                    end
                    M_CLOSING:
                    begin
                        if (idle_inc >= guard_reg)
                        begin
                            mode_next     = M_COMMAND;
                            ms_next       = 4'd0;
                            job.tail_v    = 1'b1;
                            job.tail_kind = KIND_ENTER;
                        end
                    end
                    default:
                    begin
                        if (idle_inc >= cmd_idle_reg)
                        begin
                            job.tail_v    = 1'b1;
                            job.tail_kind = KIND_LEAVE;
                            mode_next     = M_WAIT;
                            ms_next       = 4'd0;
                        end
                    end
                endcase
            end
            OP_LEAVE:
            begin
                if (mode_reg == M_COMMAND)
                begin
                    job.tail_v    = 1'b1;
                    job.tail_kind = KIND_LEAVE;
                    mode_next     = M_WAIT;
                    ms_next       = 4'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign q_job  = job;
    assign q_push = accept && (job.tail_v || (job.rep != 4'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_WAIT;
            idle_reg <= 16'd0;
            ms_reg   <= 4'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            idle_reg <= idle_next;
            ms_reg   <= ms_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_char_reg  <= 8'd43;
            marker_count_reg <= 4'd3;
            guard_reg        <= 16'd100;
            inter_reg        <= 16'd50;
            cmd_idle_reg     <= 16'd1000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MARKER_CHAR:  marker_char_reg  <= cfg_data[7:0];
                REG_MARKER_COUNT: marker_count_reg <= cfg_data[3:0];
                REG_GUARD:        guard_reg        <= cfg_data;
                REG_INTER_MARKER: inter_reg        <= cfg_data;
                REG_CMD_IDLE:     cmd_idle_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

### sv/esd_queue.sv
// ---------------------------------------------------------------------------
// esd_queue
// Two-entry job queue between the front and back halves.
// ---------------------------------------------------------------------------
module esd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  esd_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output esd_pkg::job_t head_job
);
    import esd_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/esd_back.sv
// ---------------------------------------------------------------------------
// esd_back
// Expands queued jobs into result beats through an output register.
// ---------------------------------------------------------------------------
module esd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  esd_pkg::job_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    kind,
    output logic [7:0]    out_byte,
    output logic          last
);
    import esd_pkg::*;

    logic       busy_reg;
    job_t       job_reg;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       slot_free;
    logic       emit;
    logic       emit_rep;
    logic       emit_last;

    assign q_pop     = !busy_reg && !q_empty;
    assign slot_free = !out_valid_reg || out_ready;
    assign emit      = busy_reg && slot_free;
    assign emit_rep  = (job_reg.rep != 4'd0);
    // final beat: tail, or the last marker when there is no tail
    assign emit_last = emit_rep ? ((job_reg.rep == 4'd1) && !job_reg.tail_v) : 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit && emit_last)
            begin
                busy_reg <= 1'b0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_head;
        end
        else if (emit && emit_rep)
        begin
            job_reg.rep <= job_reg.rep - 4'd1;
        end
        if (emit)
        begin
            kind_reg <= emit_rep ? KIND_DATA : job_reg.tail_kind;
            byte_reg <= emit_rep ? job_reg.mbyte : job_reg.tail_byte;
            last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign last      = last_reg;

endmodule

### sv/serial_escape_sequence_detector.sv
// ---------------------------------------------------------------------------
// serial_escape_sequence_detector
// Guard-time escape detector: data pass-through, marker run, command mode.
// ---------------------------------------------------------------------------
// The front half takes one item per cycle while the two-entry job queue has
// room; items that produce no result are taken there too but push no job.
// The back half loads a job from the queue and then sends its result beats
// through the output register, holding each while out_ready is low. An item
// has 0 to 16 results (up to fifteen released markers plus the breaking byte).
// Bursts are set by the back half; the queue lets the front keep accepting
// ticks meanwhile. Configuration writes are taken every cycle (cfg_ready is
// tied high) and must only happen while the block is idle.
module serial_escape_sequence_detector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import esd_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    job_t q_job;
    job_t q_head;

    assign cfg_ready = 1'b1;

    esd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (q_job)
    );

    esd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_head)
    );

    esd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

### sv/esd_checker.sv
// ---------------------------------------------------------------------------
// esd_checker
// Port-level checks on the result channel of the escape detector.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module esd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic [7:0]  out_byte,
    input logic        last
);
    import esd_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(kind) && $stable(out_byte) && $stable(last), "stalled result changed")
    // mode-change beats carry no byte and always close their item
    `ASSERT_CLK(a_mode_beat, clk, rst_n, out_valid && (kind == KIND_ENTER || kind == KIND_LEAVE) |-> (out_byte == 8'd0) && last, "bad mode-change beat")
    // a command byte is the only result of its item
    `ASSERT_CLK(a_cmd_single, clk, rst_n, out_valid && (kind == KIND_CMD) |-> last, "command byte not final")

endmodule

bind serial_escape_sequence_detector esd_checker u_esd_checker (.*);

### dv/esd_stream_checker.sv
// ---------------------------------------------------------------------------
// esd_stream_checker
// Watches the input, result and register channels of the escape sequence
// detector, predicts the result beats of every accepted item and compares
// each result beat in arrival order.
// ---------------------------------------------------------------------------
module esd_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  kind,
    input  logic [7:0]  out_byte,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int unsigned mismatches,
    output int unsigned pending
);
    import esd_pkg::*;

    localparam logic [7:0]  RESET_MARKER_CHAR  = 8'd43;
    localparam logic [3:0]  RESET_MARKER_COUNT = 4'd3;
    localparam logic [15:0] RESET_GUARD        = 16'd100;
    localparam logic [15:0] RESET_INTER_MARKER = 16'd50;
    localparam logic [15:0] RESET_CMD_IDLE     = 16'd1000;
    localparam int          MAX_BEATS_PER_ITEM = 16;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_ARMED,
        ST_MARKERS,
        ST_CLOSING,
        ST_COMMAND
    } det_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
    } beat_t;

    beat_t       awaited_beats[$];

    logic [7:0]  esc_char;
    logic [3:0]  esc_count;
    logic [15:0] guard_limit;
    logic [15:0] gap_limit;
    logic [15:0] cmd_idle_limit;

    det_state_t  det_state;
    logic [15:0] quiet_ticks;
    logic [3:0]  markers_held;
    int          beats_this_item;
    int unsigned error_total = 0;

    task automatic push_beat(input logic [1:0] k, input logic [7:0] d);
        beat_t b;
        if (beats_this_item < MAX_BEATS_PER_ITEM)
        begin
            b.kind = k;
            b.data = d;
            b.last = 1'b0;
            awaited_beats.push_back(b);
            beats_this_item++;
        end
    endtask

    // withheld markers go out as plain data
    task automatic release_held();
        for (int i = 0; i < markers_held; i++)
        begin
            push_beat(KIND_DATA, esc_char);
        end
    endtask

    task automatic back_to_data();
        det_state    = ST_WAIT;
        markers_held = 4'd0;
    endtask

    task automatic on_rx_byte(input logic [7:0] b);
        quiet_ticks = 16'd0;
        case (det_state)
            ST_WAIT:
            begin
                push_beat(KIND_DATA, b);
            end
            ST_ARMED:
            begin
                if (b == esc_char)
                begin
                    markers_held = 4'd1;
                    det_state    = (esc_count <= 4'd1) ? ST_CLOSING : ST_MARKERS;
                end
                else
                begin
                    push_beat(KIND_DATA, b);
                    back_to_data();
                end
            end
            ST_MARKERS:
            begin
                if (b == esc_char)
                begin
                    markers_held = markers_held + 4'd1;
                    if (markers_held >= esc_count)
                    begin
                        det_state = ST_CLOSING;
                    end
                end
                else
                begin
                    release_held();
                    push_beat(KIND_DATA, b);
                    back_to_data();
                end
            end
            ST_CLOSING:
            begin
                release_held();
                push_beat(KIND_DATA, b);
                back_to_data();
            end
            default:
            begin
                push_beat(KIND_CMD, b);
            end
        endcase
    endtask

    task automatic on_tick();
        if (quiet_ticks != 16'hFFFF)
        begin
            quiet_ticks = quiet_ticks + 16'd1;
        end
        case (det_state)
            ST_WAIT:
            begin
                if (quiet_ticks >= guard_limit)
                begin
                    quiet_ticks = 16'd0;
                    det_state   = ST_ARMED;
                end
            end
            ST_ARMED:
            begin
            end
            ST_MARKERS:
            begin
                if (quiet_ticks >= gap_limit)
                begin
                    release_held();
                    back_to_data();
                end
            end
            ST_CLOSING:
            begin
                if (quiet_ticks >= guard_limit)
                begin
                    det_state    = ST_COMMAND;
                    markers_held = 4'd0;
                    push_beat(KIND_ENTER, 8'h00);
                end
            end
            default:
            begin
                // idle count is kept on this exit
                if (quiet_ticks >= cmd_idle_limit)
                begin
                    push_beat(KIND_LEAVE, 8'h00);
                    back_to_data();
                end
            end
        endcase
    endtask

    task automatic predict_item(input logic [1:0] o, input logic [7:0] b);
        beat_t tail;
        beats_this_item = 0;
        case (o)
            OP_BYTE:
            begin
                on_rx_byte(b);
            end
            OP_TICK:
            begin
                on_tick();
            end
            OP_LEAVE:
            begin
                if (det_state == ST_COMMAND)
                begin
                    push_beat(KIND_LEAVE, 8'h00);
                    back_to_data();
                end
            end
            default:
            begin
            end
        endcase
        if (beats_this_item > 0)
        begin
            tail      = awaited_beats.pop_back();
            tail.last = 1'b1;
            awaited_beats.push_back(tail);
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        beat_t want;
        if (!rst_n)
        begin
            esc_char       = RESET_MARKER_CHAR;
            esc_count      = RESET_MARKER_COUNT;
            guard_limit    = RESET_GUARD;
            gap_limit      = RESET_INTER_MARKER;
            cmd_idle_limit = RESET_CMD_IDLE;
            det_state      = ST_WAIT;
            quiet_ticks    = 16'd0;
            markers_held   = 4'd0;
            awaited_beats.delete();
        end
        else
        begin
            // results first: a beat never belongs to an item taken on the same edge
            if (out_valid && out_ready)
            begin
                if (awaited_beats.size() == 0)
                begin
                    $display(
                        "%0t: unexpected beat, expected none, actual kind %0h byte %0h last %0b",
                        $time, kind, out_byte, last);
                    error_total++;
                end
                else
                begin
                    want = awaited_beats.pop_front();
                    compare_field("kind", {6'd0, want.kind}, {6'd0, kind});
                    compare_field("out_byte", want.data, out_byte);
                    compare_field("last", {7'd0, want.last}, {7'd0, last});
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MARKER_CHAR:  esc_char       = cfg_data[7:0];
                    REG_MARKER_COUNT: esc_count      = cfg_data[3:0];
                    REG_GUARD:        guard_limit    = cfg_data;
                    REG_INTER_MARKER: gap_limit      = cfg_data;
                    REG_CMD_IDLE:     cmd_idle_limit = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_item(op, rx_byte);
            end
        end
        pending    <= awaited_beats.size();
        mismatches <= error_total;
    end

endmodule

### dv/tb_serial_escape_sequence_detector.sv
// ---------------------------------------------------------------------------
// tb_serial_escape_sequence_detector
// Drives bytes, ticks and leave requests into the escape detector through
// several register settings, from directed escape runs to random well-formed
// and broken marker runs.
// Results are checked beat by beat by esd_stream_checker.
// ---------------------------------------------------------------------------
module tb_serial_escape_sequence_detector;
    import esd_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         TAIL_CYCLES  = 64;
    localparam int         RANDOM_ITEMS = 270;
    localparam int         RANDOM_PHASES = 5;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    int unsigned mismatches;
    int unsigned pending;

    // mirror of the register settings, used to shape the stimulus
    logic [7:0]  cur_char;
    logic [3:0]  cur_count;
    int          cur_guard;
    int          cur_gap;
    int          cur_idle;

    int          burst_left = 0;
    int          max_gap = 3;
    int          items_sent = 0;
    int          beats_seen = 0;

    serial_escape_sequence_detector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    esd_stream_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .out_byte   (out_byte),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: picks one of four stall styles at random and switches between them
    initial
    begin : receiver
        int stall_style;
        int stall_left;
        int cyc;
        stall_style = 0;
        stall_left  = 0;
        cyc         = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(16, 96);
            end
            stall_left--;
            cyc++;
            case (stall_style)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= (cyc % 3 == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ends the run when no beat moves on any channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                beats_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic send_item(input logic [1:0] o, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = (max_gap == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_gap);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_valid <= 1'b1;
        op       <= o;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        if (o != OP_UNUSED)
        begin
            items_sent++;
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, 8'($urandom));
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // upper data bits above a register's width carry junk on purpose
    task automatic load_settings(input logic [7:0] ch, input logic [3:0] cnt, input int g,
                                 input int gap, input int idle);
        cur_char  = ch;
        cur_count = cnt;
        cur_guard = g;
        cur_gap   = gap;
        cur_idle  = idle;
        write_reg(REG_MARKER_CHAR, {8'($urandom), ch});
        write_reg(REG_MARKER_COUNT, {12'($urandom), cnt});
        write_reg(REG_GUARD, 16'(g));
        write_reg(REG_INTER_MARKER, 16'(gap));
        write_reg(REG_CMD_IDLE, 16'(idle));
        cfg_valid <= 1'b0;
    endtask

    // wait until every predicted beat is out, then let the block settle
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // one escape attempt: guard silence, marker run, then either a clean entry
    // into command mode or one of the ways a run gets broken
    task automatic escape_attempt();
        int fate;
        int n_markers;
        int n_ticks;
        logic [7:0] foreign;
        fate    = $urandom_range(0, 9);
        foreign = cur_char ^ 8'($urandom_range(1, 255));
        n_ticks = cur_guard + $urandom_range(0, 1);
        if (fate == 0 && cur_guard > 0)
        begin
            n_ticks = cur_guard - 1;
        end
        send_ticks(n_ticks);
        n_markers = (cur_count == 4'd0) ? 1 : int'(cur_count);
        if (fate == 1 || fate == 2)
        begin
            n_markers = $urandom_range(0, n_markers - 1);
        end
        for (int i = 0; i < n_markers; i++)
        begin
            if (i > 0 && cur_gap > 0)
            begin
                send_ticks($urandom_range(0, (cur_gap - 1 < 3) ? cur_gap - 1 : 3));
            end
            send_item(OP_BYTE, cur_char);
        end
        case (fate)
            1:
            begin
                send_item(OP_BYTE, foreign);
            end
            2:
            begin
                send_ticks(cur_gap + 1);
            end
            3:
            begin
                send_ticks((cur_guard > 1) ? $urandom_range(0, cur_guard - 1) : 0);
                send_item(OP_BYTE, 8'($urandom));
            end
            default:
            begin
                send_ticks(cur_guard + $urandom_range(0, 1));
                repeat ($urandom_range(0, 4))
                begin
                    send_item(OP_BYTE, ($urandom_range(0, 3) == 0) ? cur_char : 8'($urandom));
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    send_item(OP_LEAVE, 8'($urandom));
                end
                else
                begin
                    send_ticks(cur_idle + 1);
                end
            end
        endcase
    endtask

    initial
    begin : stimulus
        int phase_end;
        in_valid  <= 1'b0;
        op        <= OP_BYTE;
        rx_byte   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MARKER_CHAR;
        cfg_data  <= 16'h0000;
        rst_n     <= 1'b0;
        cur_char  = 8'd43;
        cur_count = 4'd3;
        cur_guard = 100;
        cur_gap   = 50;
        cur_idle  = 1000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain data, ignored ops
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_UNUSED, 8'hA5);
        send_item(OP_LEAVE, 8'h5A);
        drain();

        load_settings(8'hFF, 4'd2, 2, 2, 3);
        send_item(OP_BYTE, 8'h00);
        send_ticks(3);                  // arms, then sits armed with no timeout
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h80);      // foreign byte breaks the run
        send_ticks(2);
        send_item(OP_BYTE, 8'hFF);
        send_ticks(3);                  // marker timeout, then re-arm
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'h7F);      // byte inside the closing silence
        send_ticks(2);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, 8'hFF);
        send_ticks(2);                  // enters command mode
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_LEAVE, 8'h00);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    max_gap = 6;
                    load_settings(8'd43, 4'd3, 4, 3, 5);
                end
                1:
                begin
                    max_gap = 0;
                    load_settings(8'h00, 4'd1, 0, 0, 0);
                end
                2:
                begin
                    max_gap = 3;
                    load_settings(8'hFF, 4'd15, 3, 2, 4);
                end
                default:
                begin
                    max_gap = $urandom_range(0, 8);
                    load_settings(8'($urandom), 4'($urandom_range(1, 15)), $urandom_range(0, 6),
                                  $urandom_range(0, 5), $urandom_range(0, 8));
                end
            endcase
            phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    escape_attempt();
                end
                else
                begin
                    repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom));
                end
            end
            drain();
        end

        $display("Sent %0d items over seven register settings, directed and random runs",
                 items_sent);
        $display("Checked %0d result beats, %0d still awaited", beats_seen, pending);
        if (mismatches == 0 && pending == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### serial_escape_sequence_detector.f
+incdir+sv
sv/esd_pkg.sv
sv/esd_front.sv
sv/esd_queue.sv
sv/esd_back.sv
sv/serial_escape_sequence_detector.sv
sv/esd_checker.sv
dv/esd_stream_checker.sv
dv/tb_serial_escape_sequence_detector.sv
